FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/wmrc_pkg.sv
package wmrc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int RATIO_W   = FRAC_BITS + 4;
  localparam int IN_W      = 104;
  localparam int OUT_W     = 72;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 20;
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 32;

  localparam logic [RATIO_W-1:0] ONE_Q = RATIO_W'(1) << FRAC_BITS;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MIN_EST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HARD_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HARD_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAND       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT      = 3'd5;

  localparam logic [15:0] MIN_EST_RST   = 16'd256;
  localparam logic [19:0] HARD_LOW_RST  = 20'd16384;
  localparam logic [19:0] HARD_HIGH_RST = 20'd262144;
  localparam logic [4:0]  MIN_SAMP_RST  = 5'd2;
  localparam logic [15:0] BAND_RST      = 16'd19661;
  localparam logic [19:0] DRIFT_RST     = 20'd98304;

  typedef enum logic [2:0] {
    V_ACCEPT    = 3'd0,
    V_INVALID   = 3'd1,
    V_HARD_BAND = 3'd2,
    V_ANOMALY   = 3'd3,
    V_WIN_RESET = 3'd4
  } verdict_t;

  typedef enum logic [1:0] {
    DIV_RATIO,
    DIV_PERBYTE,
    DIV_DEV
  } div_sel_t;

  typedef enum logic [1:0] {
    MUL_ABOVE,
    MUL_BELOW,
    MUL_DRIFT_MED,
    MUL_DRIFT_RATIO
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_go;
    div_sel_t div_sel;
    logic     cap_ratio;
    logic     cap_pb;
    logic     cap_dev;
    logic     sort_clr;
    logic     rd;
    logic     pick_lo;
    logic     pick_hi;
    logic     med_avg;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     mag_go;
    logic     push;
    logic     win_reset;
    logic     set_pend;
    logic     set_verdict;
    verdict_t verdict;
  } cmd_t;

  typedef struct packed {
    logic bad_bucket;
    logic invalid;
    logic hard_ok;
    logic cal;
    logic pend;
    logic rd_last;
    logic div_done;
    logic above;
    logic below;
    logic drift;
    logic coef_zero;
  } stat_t;

endpackage

FILE: design/wmrc_div.sv
module wmrc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [wmrc_pkg::DIV_NUM_W-1:0] num,
  input  logic [wmrc_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [wmrc_pkg::RATIO_W-1:0]   q
);
  import wmrc_pkg::*;

  localparam int STEP_W = $clog2(RATIO_W + 1);

  logic                 busy;
  logic [STEP_W-1:0]    steps;
  logic [DIV_DEN_W-1:0] rem;
  logic [RATIO_W-1:0]   bits;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  // One quotient bit per cycle, restoring
  assign trial = {rem, bits[RATIO_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den == '0) begin
          q    <= '0;
          done <= 1'b1;
        end else if (DIV_DEN_W'(num[DIV_NUM_W-1:RATIO_W]) >= den) begin
          q    <= '1;
          done <= 1'b1;
        end else begin
          rem   <= DIV_DEN_W'(num[DIV_NUM_W-1:RATIO_W]);
          bits  <= num[RATIO_W-1:0];
          steps <= STEP_W'(RATIO_W);
          busy  <= 1'b1;
        end
      end else if (busy) begin
        rem   <= fits ? DIV_DEN_W'(trial - {1'b0, den}) : trial[DIV_DEN_W-1:0];
        bits  <= {bits[RATIO_W-2:0], 1'b0};
        q     <= {q[RATIO_W-2:0], fits};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/wmrc_sort.sv
module wmrc_sort #(
  parameter int WINDOW = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clr,
  input  logic                         ins,
  input  logic [wmrc_pkg::RATIO_W-1:0] din,
  input  logic [$clog2(WINDOW)-1:0]    idx,
  output logic [wmrc_pkg::RATIO_W-1:0] pick
);
  import wmrc_pkg::*;

  logic [RATIO_W-1:0] srt [WINDOW];
  logic [WINDOW-1:0]  vld;
  logic [WINDOW-1:0]  gt;

  // Empty lanes count as larger than any value, so gt is monotone
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      gt[i] = !vld[i] || (srt[i] > din);
    end
  end

  for (genvar g = 0; g < WINDOW; g++) begin : g_lane
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (ins && gt[0]) begin
          srt[0] <= din;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (ins && gt[g]) begin
          srt[g] <= gt[g-1] ? srt[g-1] : din;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (ins) begin
      vld <= {vld[WINDOW-2:0], 1'b1} | vld;
    end
  end

  assign pick = srt[idx];

endmodule

FILE: design/wmrc_dp.sv
module wmrc_dp #(
  parameter int NUM_BUCKETS = 16,
  parameter int WINDOW      = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [wmrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wmrc_pkg::CFG_W-1:0]     cfg_data,
  input  logic [3:0]                     bucket,
  input  logic [31:0]                    reported_tokens,
  input  logic [31:0]                    est_tokens,
  input  logic [31:0]                    req_bytes,
  input  wmrc_pkg::cmd_t                 cmd,
  output wmrc_pkg::stat_t                stat,
  output logic [2:0]                     verdict,
  output logic [4:0]                     win_count,
  output logic                           calibrated,
  output logic [19:0]                    coefficient,
  output logic [19:0]                    per_byte_med,
  output logic [15:0]                    deviation_percent
);
  import wmrc_pkg::*;

  localparam int NB_USED = (NUM_BUCKETS < 16) ? NUM_BUCKETS : 16;
  localparam int BKT_W   = (NB_USED > 1) ? $clog2(NB_USED) : 1;
  localparam int SLOT_W  = $clog2(WINDOW);
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int ADDR_W  = BKT_W + SLOT_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int MAG_W   = 27;

  // Configuration
  logic [15:0] min_est;
  logic [19:0] hard_low;
  logic [19:0] hard_high;
  logic [4:0]  min_samples;
  logic [15:0] band;
  logic [19:0] drift_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_est      <= MIN_EST_RST;
      hard_low     <= HARD_LOW_RST;
      hard_high    <= HARD_HIGH_RST;
      min_samples  <= MIN_SAMP_RST;
      band         <= BAND_RST;
      drift_factor <= DRIFT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_EST:   min_est      <= cfg_data[15:0];
        REG_HARD_LOW:  hard_low     <= cfg_data;
        REG_HARD_HIGH: hard_high    <= cfg_data;
        REG_MIN_SAMP:  min_samples  <= cfg_data[4:0];
        REG_BAND:      band         <= cfg_data[15:0];
        REG_DRIFT:     drift_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sample registers
  logic [3:0]  bkt;
  logic [31:0] rep;
  logic [31:0] est;
  logic [31:0] nbytes;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bkt    <= bucket;
      rep    <= reported_tokens;
      est    <= est_tokens;
      nbytes <= req_bytes;
    end
  end

  logic [BKT_W-1:0] bidx;
  logic             bad;
  assign bidx = bkt[BKT_W-1:0];
  assign bad  = 9'(bkt) >= 9'(NUM_BUCKETS);

  // Per-bucket ring state
  logic [SLOT_W-1:0] head_tab [NB_USED];
  logic [CNT_W-1:0]  cnt_tab  [NB_USED];
  logic [NB_USED-1:0] pend_tab;

  logic [SLOT_W-1:0] cur_head;
  logic [CNT_W-1:0]  cur_cnt;
  logic [4:0]        eff_min;
  logic              cal;

  assign cur_head = head_tab[bidx];
  assign cur_cnt  = cnt_tab[bidx];
  assign eff_min  = (min_samples == 5'd0) ? 5'd1 : min_samples;
  assign cal      = !bad && (8'(cur_cnt) >= 8'(eff_min));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NB_USED; i++) begin
        head_tab[i] <= '0;
        cnt_tab[i]  <= '0;
      end
      pend_tab <= '0;
    end else if (cmd.push) begin
      head_tab[bidx] <= (cur_head == SLOT_W'(WINDOW - 1)) ? '0 : cur_head + SLOT_W'(1);
      if (cur_cnt != CNT_W'(WINDOW)) begin
        cnt_tab[bidx] <= cur_cnt + CNT_W'(1);
      end
      pend_tab[bidx] <= 1'b0;
    end else if (cmd.win_reset) begin
      head_tab[bidx] <= SLOT_W'(1);
      cnt_tab[bidx]  <= CNT_W'(1);
      pend_tab[bidx] <= 1'b0;
    end else if (cmd.set_pend) begin
      pend_tab[bidx] <= 1'b1;
    end
  end

  // Serial divider, shared by both ratios and the deviation
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [RATIO_W-1:0]   div_q;
  logic [RATIO_W-1:0]   ratio_r;
  logic [RATIO_W-1:0]   pb_r;
  logic [RATIO_W-1:0]   med_r;
  logic [RATIO_W-1:0]   medp_r;
  logic [MAG_W-1:0]     mag_r;
  logic                 neg_r;

  always_comb begin
    case (cmd.div_sel)
      DIV_RATIO: begin
        div_num = {rep, 16'd0};
        div_den = est;
      end
      DIV_PERBYTE: begin
        div_num = {rep, 16'd0};
        div_den = nbytes;
      end
      default: begin
        div_num = DIV_NUM_W'({mag_r, 1'b0}) + DIV_NUM_W'(med_r);
        div_den = DIV_DEN_W'({med_r, 1'b0});
      end
    endcase
  end

  wmrc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  // Window memories
  logic [RATIO_W-1:0] ratio_mem [DEPTH];
  logic [RATIO_W-1:0] pb_mem    [DEPTH];
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [SLOT_W-1:0]  rd_slot;
  logic               rd_v;
  logic [RATIO_W-1:0] ratio_rd;
  logic [RATIO_W-1:0] pb_rd;

  assign wr_addr = {bidx, cmd.win_reset ? SLOT_W'(0) : cur_head};
  assign rd_addr = {bidx, rd_slot};

  always_ff @(posedge clk) begin
    if (cmd.push || cmd.win_reset) begin
      ratio_mem[wr_addr] <= ratio_r;
    end
    if (cmd.rd) begin
      ratio_rd <= ratio_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push || cmd.win_reset) begin
      pb_mem[wr_addr] <= pb_r;
    end
    if (cmd.rd) begin
      pb_rd <= pb_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v    <= 1'b0;
      rd_slot <= '0;
    end else begin
      rd_v <= cmd.rd;
      if (cmd.sort_clr) begin
        rd_slot <= '0;
      end else if (cmd.rd) begin
        rd_slot <= rd_slot + SLOT_W'(1);
      end
    end
  end

  // Sorters and median pick
  logic [SLOT_W-1:0]  idx_lo;
  logic [SLOT_W-1:0]  idx_hi;
  logic [RATIO_W-1:0] ratio_pick;
  logic [RATIO_W-1:0] pb_pick;
  logic [RATIO_W-1:0] ratio_lo;
  logic [RATIO_W-1:0] ratio_hi;
  logic [RATIO_W-1:0] pb_lo;
  logic [RATIO_W-1:0] pb_hi;

  assign idx_lo = SLOT_W'((cur_cnt - CNT_W'(1)) >> 1);
  assign idx_hi = SLOT_W'(cur_cnt >> 1);

  wmrc_sort #(.WINDOW(WINDOW)) u_sort_ratio (
    .clk  (clk),
    .rst  (rst),
    .clr  (cmd.sort_clr),
    .ins  (rd_v),
    .din  (ratio_rd),
    .idx  (cmd.pick_hi ? idx_hi : idx_lo),
    .pick (ratio_pick)
  );

  wmrc_sort #(.WINDOW(WINDOW)) u_sort_pb (
    .clk  (clk),
    .rst  (rst),
    .clr  (cmd.sort_clr),
    .ins  (rd_v),
    .din  (pb_rd),
    .idx  (cmd.pick_hi ? idx_hi : idx_lo),
    .pick (pb_pick)
  );

  // Band and drift products, one per cycle, each compared in the cycle after it is formed
  logic [RATIO_W-1:0] mul_a;
  logic [RATIO_W-1:0] mul_b;
  logic [39:0]        prod;
  mul_sel_t           psel;
  logic               pv;
  logic [39:0]        rs;
  logic [39:0]        meds;
  logic               above_f;
  logic               below_f;
  logic               drc_f;
  logic               drd_f;

  assign rs   = {4'd0, ratio_r, 16'd0};
  assign meds = {4'd0, med_r, 16'd0};

  always_comb begin
    mul_a = (cmd.mul_sel == MUL_DRIFT_RATIO) ? ratio_r : med_r;
    case (cmd.mul_sel)
      MUL_ABOVE: mul_b = ONE_Q + RATIO_W'(band);
      MUL_BELOW: mul_b = ONE_Q - RATIO_W'(band);
      default:   mul_b = drift_factor;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod <= 40'(mul_a) * 40'(mul_b);
      psel <= cmd.mul_sel;
    end
    if (pv) begin
      case (psel)
        MUL_ABOVE:     above_f <= rs > prod;
        MUL_BELOW:     below_f <= rs < prod;
        MUL_DRIFT_MED: drc_f   <= rs > prod;
        default:       drd_f   <= prod < meds;
      endcase
    end
  end

  // Result registers
  logic [RATIO_W-1:0] diff;
  verdict_t           verdict_r;
  logic [15:0]        dev_r;

  assign diff = (med_r > ONE_Q) ? med_r - ONE_Q : ONE_Q - med_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dev_r <= '0;
    end
    if (cmd.set_verdict) begin
      verdict_r <= cmd.verdict;
    end
    if (cmd.cap_ratio) begin
      ratio_r <= div_q;
    end
    if (cmd.cap_pb) begin
      pb_r <= div_q;
    end
    if (cmd.pick_lo) begin
      ratio_lo <= ratio_pick;
      pb_lo    <= pb_pick;
    end
    if (cmd.pick_hi) begin
      ratio_hi <= ratio_pick;
      pb_hi    <= pb_pick;
    end
    if (cmd.med_avg) begin
      med_r  <= RATIO_W'(((RATIO_W + 1)'(ratio_lo) + (RATIO_W + 1)'(ratio_hi)) >> 1);
      medp_r <= RATIO_W'(((RATIO_W + 1)'(pb_lo) + (RATIO_W + 1)'(pb_hi)) >> 1);
    end
    if (cmd.mag_go) begin
      mag_r <= MAG_W'(diff) * MAG_W'(100);
      neg_r <= med_r > ONE_Q;
    end
    if (cmd.cap_dev) begin
      if (neg_r) begin
        dev_r <= (div_q > RATIO_W'(32768)) ? 16'h8000 : 16'(-div_q);
      end else begin
        dev_r <= (div_q > RATIO_W'(32767)) ? 16'h7FFF : div_q[15:0];
      end
    end
  end

  always_comb begin
    stat.bad_bucket = bad;
    stat.invalid    = (rep == '0) || rep[31] || (nbytes == '0) || (est < 32'(min_est));
    stat.hard_ok    = (ratio_r >= hard_low) && (ratio_r <= hard_high);
    stat.cal        = cal;
    stat.pend       = pend_tab[bidx];
    stat.rd_last    = rd_slot == SLOT_W'(cur_cnt - CNT_W'(1));
    stat.div_done   = div_done;
    stat.above      = above_f;
    stat.below      = below_f;
    stat.drift      = drc_f || drd_f;
    stat.coef_zero  = med_r == '0;
  end

  assign verdict           = verdict_r;
  assign win_count         = bad ? 5'd0 : 5'(cur_cnt);
  assign calibrated        = cal;
  assign coefficient       = cal ? med_r : ONE_Q;
  assign per_byte_med      = cal ? medp_r : '0;
  assign deviation_percent = cal ? dev_r : '0;

endmodule

FILE: design/wmrc_ctrl.sv
module wmrc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  wmrc_pkg::stat_t stat,
  output wmrc_pkg::cmd_t  cmd
);
  import wmrc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_DIV_R, S_DIVP_GO, S_DIV_P, S_HARD,
    S_SCLR, S_LOAD, S_LWAIT, S_PICK_LO, S_PICK_HI, S_AVG,
    S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_MULW, S_DECIDE,
    S_STATUS, S_MAG, S_DEV_GO, S_DIV_D, S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   final_phase;
  logic   final_phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      final_phase <= 1'b0;
    end else begin
      state       <= state_next;
      final_phase <= final_phase_next;
    end
  end

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_OUT;

  always_comb begin
    cmd              = '0;
    state_next       = state;
    final_phase_next = final_phase;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.bad_bucket || stat.invalid) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = V_INVALID;
          state_next      = stat.bad_bucket ? S_OUT : S_STATUS;
        end else begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = DIV_RATIO;
          state_next  = S_DIV_R;
        end
      end
      S_DIV_R: begin
        if (stat.div_done) begin
          cmd.cap_ratio = 1'b1;
          state_next    = S_DIVP_GO;
        end
      end
      S_DIVP_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_PERBYTE;
        state_next  = S_DIV_P;
      end
      S_DIV_P: begin
        cmd.div_sel = DIV_PERBYTE;
        if (stat.div_done) begin
          cmd.cap_pb = 1'b1;
          state_next = S_HARD;
        end
      end
      S_HARD: begin
        if (!stat.hard_ok) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = V_HARD_BAND;
          state_next      = S_STATUS;
        end else if (stat.cal) begin
          final_phase_next = 1'b0;
          state_next       = S_SCLR;
        end else begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = V_ACCEPT;
          cmd.push        = 1'b1;
          state_next      = S_STATUS;
        end
      end
      S_SCLR: begin
        cmd.sort_clr = 1'b1;
        state_next   = S_LOAD;
      end
      S_LOAD: begin
        cmd.rd = 1'b1;
        if (stat.rd_last) begin
          state_next = S_LWAIT;
        end
      end
      S_LWAIT: begin
        state_next = S_PICK_LO;
      end
      S_PICK_LO: begin
        cmd.pick_lo = 1'b1;
        state_next  = S_PICK_HI;
      end
      S_PICK_HI: begin
        cmd.pick_hi = 1'b1;
        state_next  = S_AVG;
      end
      S_AVG: begin
        cmd.med_avg = 1'b1;
        state_next  = final_phase ? S_MAG : S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_ABOVE;
        state_next  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_BELOW;
        state_next  = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_DRIFT_MED;
        state_next  = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_DRIFT_RATIO;
        state_next  = S_MULW;
      end
      S_MULW: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.set_verdict = 1'b1;
        state_next      = S_STATUS;
        if (stat.above || stat.below) begin
          if (stat.drift && stat.pend) begin
            cmd.verdict   = V_WIN_RESET;
            cmd.win_reset = 1'b1;
          end else begin
            cmd.verdict  = V_ANOMALY;
            cmd.set_pend = 1'b1;
          end
        end else begin
          cmd.verdict = V_ACCEPT;
          cmd.push    = 1'b1;
        end
      end
      S_STATUS: begin
        if (stat.cal) begin
          final_phase_next = 1'b1;
          state_next       = S_SCLR;
        end else begin
          state_next = S_OUT;
        end
      end
      S_MAG: begin
        cmd.mag_go = 1'b1;
        state_next = S_DEV_GO;
      end
      S_DEV_GO: begin
        if (stat.coef_zero) begin
          state_next = S_OUT;
        end else begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = DIV_DEV;
          state_next  = S_DIV_D;
        end
      end
      S_DIV_D: begin
        cmd.div_sel = DIV_DEV;
        if (stat.div_done) begin
          cmd.cap_dev = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/windowed_median_ratio_calibrator_unit.sv
// Windowed median ratio calibrator. Each input word is one measurement for a
// bucket; the block checks it against the hard ratio band and, once the
// bucket window is calibrated, against the median plus or minus the anomaly
// band, updates the bucket ring and returns one result word with the verdict
// and the bucket status after the update. One word is in work at a time: the
// input is ready only while the block is idle and stays low until the result
// word has been taken. A sample that goes through the anomaly check takes
// longest, and longer the fuller its bucket window is; rejected or
// uncalibrated samples finish sooner, and a bad bucket index goes straight
// from the check to the result word. The time is set by the serial divider,
// which yields one quotient bit per cycle and runs up to three times per
// sample, and by the window RAM port, which feeds one stored entry per cycle
// into the insertion sorters, once for the anomaly check and once for the
// status after the update. Bucket state clears at reset at once; the window
// RAMs need no clearing pass, since only written entries are read.
// Configuration writes take effect at once and are to be made while the block
// is idle.
module windowed_median_ratio_calibrator_unit #(
  parameter int NUM_BUCKETS = 16,
  parameter int WINDOW      = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // bucket[3:0], reported count[35:4], estimated count[67:36],
  // request size[99:68], zero fill[103:100]
  input  logic [wmrc_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // verdict[2:0], window count[7:3], calibrated[8], coefficient[28:9],
  // per-byte median[48:29], deviation_percent[64:49], zero fill[71:65]
  output logic [wmrc_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                           cfg_we,
  input  logic [wmrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wmrc_pkg::CFG_W-1:0]     cfg_data
);
  import wmrc_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  logic [2:0]  verdict;
  logic [4:0]  win_count;
  logic        calibrated;
  logic [19:0] coefficient;
  logic [19:0] per_byte_med;
  logic [15:0] deviation_percent;

  // Sequence the divisions, median passes and ring updates
  wmrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the sample, bucket tables, window RAMs and arithmetic
  wmrc_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WINDOW      (WINDOW)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .bucket            (s_axis_tdata[3:0]),
    .reported_tokens   (s_axis_tdata[35:4]),
    .est_tokens        (s_axis_tdata[67:36]),
    .req_bytes         (s_axis_tdata[99:68]),
    .cmd               (cmd),
    .stat              (stat),
    .verdict           (verdict),
    .win_count         (win_count),
    .calibrated        (calibrated),
    .coefficient       (coefficient),
    .per_byte_med      (per_byte_med),
    .deviation_percent (deviation_percent)
  );

  // Result fields stay put from their registers while the word waits
  assign m_axis_tdata = {7'd0, deviation_percent, per_byte_med, coefficient,
                         calibrated, win_count, verdict};

endmodule

FILE: design/wmrc_checker.sv
module wmrc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [wmrc_pkg::OUT_W-1:0] m_axis_tdata
);
`include "assert_macros.svh"

  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && m_axis_tvalid, "result word changed while stalled")

  `ASSERT_IMPLIES(a_one_in_work, clk, rst, m_axis_tvalid, !s_axis_tready, "input ready while a result waits")

  `ASSERT_NEXT(a_ready_drops, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid, "block not busy after accepting a word")

  `ASSERT_IMPLIES(a_uncal_values, clk, rst, m_axis_tvalid && !m_axis_tdata[8], (m_axis_tdata[28:9] == 20'h10000) && (m_axis_tdata[48:29] == 20'd0) && (m_axis_tdata[64:49] == 16'd0), "uncalibrated status not neutral")

endmodule

bind windowed_median_ratio_calibrator_unit wmrc_checker u_wmrc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: sim/windowed_median_ratio_calibrator_unit_test.sv
module windowed_median_ratio_calibrator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wmrc_pkg::*;

  localparam int NB  = 16;
  localparam int WIN = 16;

  typedef struct packed {
    logic [31:0] req_bytes;
    logic [31:0] est_tokens;
    logic [31:0] reported_tokens;
    logic [3:0]  bucket;
  } sample_t;

  typedef struct packed {
    logic [15:0] deviation_percent;
    logic [19:0] per_byte_med;
    logic [19:0] coefficient;
    logic        calibrated;
    logic [4:0]  win_count;
    verdict_t    verdict;
  } status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // bucket, reported count, estimated count, request size, zero fill
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // verdict, window count, calibrated, coefficient, per-byte median,
  // deviation_percent, zero fill
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  windowed_median_ratio_calibrator_unit #(.NUM_BUCKETS(NB), .WINDOW(WIN)) u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Calibration settings as the block should hold them
  logic [15:0] min_est;
  logic [19:0] hard_low, hard_high, drift_fac;
  logic [4:0]  min_samp;
  logic [15:0] band;

  // Per-bucket window mirror
  logic [19:0] ratio_ring [NB][WIN];
  logic [19:0] per_byte_ring [NB][WIN];
  int          ring_wr [NB];
  int          ring_fill [NB];
  bit          pend [NB];

  sample_t pending_words[$];  // words waiting for the driver
  status_t status_fifo[$];    // predicted status, oldest first
  int      errors = 0;
  bit      quiet = 1'b0;      // last part of the run: no idling
  bit      hold_send = 1'b0;  // sender held off
  int      gap_left = 0, stall_left = 0;
  longint  cycles = 0;

  function automatic void enqueue_word(sample_t s);
    pending_words = {pending_words, s};
  endfunction

  function automatic logic [19:0] qdiv(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    if (den == 0) return '0;
    q = (num << 16) / den;
    return (q > 64'hFFFFF) ? 20'hFFFFF : q[19:0];
  endfunction

  function automatic logic [19:0] median20(int b, int n, bit use_ratio);
    logic [19:0] v [$];
    if (n == 0) return '0;
    for (int i = 0; i < n; i++) v = {v, (use_ratio ? ratio_ring[b][i] : per_byte_ring[b][i])};
    v.sort();
    if (n % 2) return v[n/2];
    return 20'((64'(v[n/2-1]) + 64'(v[n/2])) / 2);
  endfunction

  function automatic int eff_min_samples();
    return (min_samp == 0) ? 1 : int'(min_samp);
  endfunction

  function automatic void push_window(int b, logic [19:0] r, logic [19:0] p);
    ratio_ring[b][ring_wr[b]] = r;
    per_byte_ring[b][ring_wr[b]] = p;
    ring_wr[b] = (ring_wr[b] + 1) % WIN;
    if (ring_fill[b] < WIN) ring_fill[b]++;
  endfunction

  // Work out the status word that one sample produces, and update the mirror
  function automatic status_t calibrate_sample(sample_t s);
    status_t o;
    int b;
    logic [63:0] rep, est, byt, med, rs, mag, q;
    logic [19:0] ratio, pb;
    longint num;
    bit above, below, drift;
    b = s.bucket;
    rep = s.reported_tokens;
    est = s.est_tokens;
    byt = s.req_bytes;
    o = '0;
    if (rep == 0 || rep[31] || byt == 0 || est < min_est) begin
      o.verdict = V_INVALID;
    end else begin
      ratio = qdiv(rep, est);
      pb = qdiv(rep, byt);
      if (!(ratio >= hard_low && ratio <= hard_high)) begin
        o.verdict = V_HARD_BAND;
      end else begin
        o.verdict = V_ACCEPT;
        if (ring_fill[b] >= eff_min_samples()) begin
          med = median20(b, ring_fill[b], 1'b1);
          rs = 64'(ratio) << 16;
          above = rs > med * (64'd65536 + band);
          below = rs < med * (64'd65536 - band);
          if (above || below) begin
            drift = rs > med * drift_fac || 64'(ratio) * drift_fac < (med << 16);
            if (drift && pend[b]) begin
              ring_fill[b] = 0;
              ring_wr[b] = 0;
              push_window(b, ratio, pb);
              pend[b] = 1'b0;
              o.verdict = V_WIN_RESET;
            end else begin
              pend[b] = 1'b1;
              o.verdict = V_ANOMALY;
            end
          end
        end
        if (o.verdict == V_ACCEPT) begin
          pend[b] = 1'b0;
          push_window(b, ratio, pb);
        end
      end
    end
    o.win_count = 5'(ring_fill[b]);
    o.calibrated = ring_fill[b] >= eff_min_samples();
    o.coefficient = ONE_Q;
    if (o.calibrated) begin
      o.coefficient = median20(b, ring_fill[b], 1'b1);
      o.per_byte_med = median20(b, ring_fill[b], 1'b0);
      if (o.coefficient != 0) begin
        num = (longint'(65536) - longint'(o.coefficient)) * 100;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + o.coefficient) / (2 * 64'(o.coefficient));
        if (q > 32768) q = 32768;
        if (num >= 0 && q > 32767) q = 32767;
        o.deviation_percent = (num < 0) ? 16'(-longint'(q)) : 16'(q);
      end
    end
    return o;
  endfunction

  // Driver: present the next pending word, idle in random bursts
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        status_fifo = {status_fifo, calibrate_sample(sample_t'(s_axis_tdata[99:0]))};
        if (!quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 5);
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (!hold_send && pending_words.size() > 0) begin
          s_axis_tdata <= {4'b0, pending_words.pop_front()};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take result words with random stalls and check each field
  always @(posedge clk) begin
    status_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = status_t'(m_axis_tdata[64:0]);
        if (status_fifo.size() == 0) begin
          $error("result word with nothing expected: %h", m_axis_tdata);
          errors++;
        end else begin
          want = status_fifo.pop_front();
          if (got.verdict !== want.verdict) begin
            $error("verdict exp %0d got %0d", want.verdict, got.verdict); errors++;
          end
          if (got.win_count !== want.win_count) begin
            $error("win_count exp %0d got %0d", want.win_count, got.win_count);
            errors++;
          end
          if (got.calibrated !== want.calibrated) begin
            $error("calibrated exp %0d got %0d", want.calibrated, got.calibrated); errors++;
          end
          if (got.coefficient !== want.coefficient) begin
            $error("coefficient exp %0d got %0d", want.coefficient, got.coefficient); errors++;
          end
          if (got.per_byte_med !== want.per_byte_med) begin
            $error("per_byte_med exp %0d got %0d", want.per_byte_med,
                   got.per_byte_med);
            errors++;
          end
          if (got.deviation_percent !== want.deviation_percent) begin
            $error("deviation_percent exp %0d got %0d", $signed(want.deviation_percent),
                   $signed(got.deviation_percent));
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: the bound covers full-window words plus both sides idling
  always @(posedge clk) begin
    cycles++;
    if (cycles > 2_000_000) begin
      $display("windowed_median_ratio_calibrator_unit_test: done, errors");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MIN_EST:   min_est = val[15:0];
      REG_HARD_LOW:  hard_low = val;
      REG_HARD_HIGH: hard_high = val;
      REG_MIN_SAMP:  min_samp = val[4:0];
      REG_BAND:      band = val[15:0];
      REG_DRIFT:     drift_fac = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Wait for the block to drain completely, then a little longer
  task automatic drain();
    do @(negedge clk);
    while (pending_words.size() != 0 || s_axis_tvalid || status_fifo.size() != 0);
    repeat (200) @(posedge clk);
  endtask

  function automatic sample_t mk(int b, logic [31:0] rep, logic [31:0] est,
                                 logic [31:0] byt);
    sample_t s;
    s.bucket = 4'(b);
    s.reported_tokens = rep;
    s.est_tokens = est;
    s.req_bytes = byt;
    return s;
  endfunction

  // Well-formed sample near a given ratio (Q4.16) with some spread
  function automatic sample_t near(int b, int ratio_q, int spread_pct);
    logic [31:0] est, rep;
    longint r;
    est = $urandom_range(300, 200000);
    r = longint'(ratio_q) * (100 - spread_pct + $urandom_range(0, 2 * spread_pct)) / 100;
    rep = 32'((longint'(est) * r) >> 16);
    if (rep == 0) rep = 1;
    return mk(b, rep, est, $urandom_range(1, 1 << $urandom_range(1, 31)));
  endfunction

  function automatic sample_t noise();
    return mk($urandom_range(0, 15), $urandom, $urandom >> $urandom_range(0, 31),
              $urandom >> $urandom_range(0, 31));
  endfunction

  task automatic random_phase(int n, int spread);
    int b, base [NB];
    for (int i = 0; i < NB; i++) base[i] = $urandom_range(20000, 200000);
    for (int i = 0; i < n; i++) begin
      b = $urandom_range(0, 15);
      case ($urandom_range(0, 9))
        0: enqueue_word(noise());
        1: enqueue_word(near(b, base[b] * $urandom_range(2, 4), 5));
        2: enqueue_word(near(b, base[b] / $urandom_range(2, 4), 5));
        default: enqueue_word(near(b, base[b], spread));
      endcase
    end
  endtask

  initial begin
    min_est = MIN_EST_RST; hard_low = HARD_LOW_RST; hard_high = HARD_HIGH_RST;
    min_samp = MIN_SAMP_RST; band = BAND_RST; drift_fac = DRIFT_RST;
    for (int b = 0; b < NB; b++) begin
      ring_wr[b] = 0; ring_fill[b] = 0; pend[b] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: invalid forms, hard band edges, saturation, anomaly then drift reset
    enqueue_word(mk(0, 32'h8000_0000, 1000, 100));
    enqueue_word(mk(0, 0, 1000, 100));
    enqueue_word(mk(0, 100, 255, 100));
    enqueue_word(mk(0, 100, 1000, 0));
    enqueue_word(mk(0, 32'h7FFF_FFFF, 256, 1));
    enqueue_word(mk(1, 1024, 4096, 32'hFFFF_FFFF));
    enqueue_word(mk(1, 16384, 4096, 1));
    enqueue_word(mk(1, 16385, 4096, 3));
    enqueue_word(mk(2, 1000, 1000, 500));
    enqueue_word(mk(2, 1000, 1000, 500));
    enqueue_word(mk(2, 1100, 1000, 500));
    enqueue_word(mk(2, 3000, 1000, 500));
    enqueue_word(mk(2, 3000, 1000, 500));
    enqueue_word(mk(2, 400, 1000, 500));
    enqueue_word(mk(15, 2000, 32'hFFFF_FFFF, 7));
    for (int i = 0; i < 18; i++) enqueue_word(near(3, 90000, 3));
    drain();

    // Extreme settings: zero minimum estimate, widest hard band, zero anomaly band, threshold of zero
    write_reg(REG_MIN_EST, CFG_W'(0));
    write_reg(REG_HARD_LOW, CFG_W'(0));
    write_reg(REG_HARD_HIGH, CFG_W'(20'hFFFFF));
    write_reg(REG_MIN_SAMP, CFG_W'(0));
    write_reg(REG_BAND, CFG_W'(0));
    write_reg(REG_DRIFT, CFG_W'(65536));
    enqueue_word(mk(4, 5, 0, 9));
    enqueue_word(mk(4, 32'h7FFF_FFFF, 1, 1));
    enqueue_word(mk(4, 1, 32'hFFFF_FFFF, 1));
    random_phase(300, 40);
    drain();

    // Held-off sender: all results in before more words go out
    hold_send = 1'b1;
    random_phase(50, 10);
    repeat (50) @(posedge clk);
    hold_send = 1'b0;
    drain();

    // Large threshold: never calibrated
    write_reg(REG_MIN_SAMP, CFG_W'(31));
    write_reg(REG_BAND, CFG_W'(16'hFFFF));
    write_reg(REG_DRIFT, CFG_W'(20'hFFFFF));
    write_reg(REG_MIN_EST, CFG_W'(16'hFFFF));
    random_phase(150, 20);
    drain();

    // Typical settings with random thresholds
    write_reg(REG_MIN_EST, CFG_W'($urandom_range(0, 4000)));
    write_reg(REG_HARD_LOW, CFG_W'($urandom_range(0, 30000)));
    write_reg(REG_HARD_HIGH, CFG_W'($urandom_range(300000, 1048575)));
    write_reg(REG_MIN_SAMP, CFG_W'(16));
    write_reg(REG_BAND, CFG_W'($urandom_range(2000, 20000)));
    write_reg(REG_DRIFT, CFG_W'($urandom_range(70000, 200000)));
    random_phase(500, 8);
    drain();

    write_reg(REG_MIN_SAMP, CFG_W'(1));
    write_reg(REG_BAND, CFG_W'(19661));
    write_reg(REG_DRIFT, CFG_W'(98304));
    random_phase(450, 15);
    while (pending_words.size() >= 100) @(posedge clk);
    quiet = 1'b1;
    drain();

    if (errors == 0) begin
      $display("windowed_median_ratio_calibrator_unit_test: done, clean");
    end else begin
      $display("windowed_median_ratio_calibrator_unit_test: done, errors");
    end
    $finish;
  end
endmodule
